### src/achrs_pkg.sv
`default_nettype none
package achrs_pkg;

    localparam int MAX_DIGITS_DEF = 7;
    localparam int MAX_REPORTS    = 16;
    localparam int RUN_DIGITS     = (MAX_REPORTS - 2) / 2;
    localparam int CODE_W         = 25;
    localparam int MAG_W          = 26;
    localparam int BCD_DIGITS     = 8;
    localparam int BCD_W          = 4 * BCD_DIGITS;
    localparam int ND_W           = 4;
    localparam int CONV_STEPS     = MAG_W / 2;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic REQ_ALT = 1'b0;
    localparam logic REQ_CTL = 1'b1;

    localparam logic [7:0] MOD_ALT  = 8'h04;
    localparam logic [7:0] MOD_NONE = 8'h00;
    localparam logic [7:0] KEY_NONE = 8'h00;

    localparam logic [2:0] CK_ENTER     = 3'd0;
    localparam logic [2:0] CK_SPACE     = 3'd1;
    localparam logic [2:0] CK_TAB       = 3'd2;
    localparam logic [2:0] CK_BACKSPACE = 3'd3;
    localparam logic [2:0] CK_ESCAPE    = 3'd4;

    typedef struct packed {
        logic       is_ctl;
        logic [7:0] ctl_usage;
    } qhead_t;

    function automatic logic [7:0] numpad_usage(input logic [3:0] d);
        logic [7:0] u;
        case (d)
            4'd1: u = 8'h59;
            4'd2: u = 8'h5a;
            4'd3: u = 8'h5b;
            4'd4: u = 8'h5c;
            4'd5: u = 8'h5d;
            4'd6: u = 8'h5e;
            4'd7: u = 8'h5f;
            4'd8: u = 8'h60;
            4'd9: u = 8'h61;
            default: u = 8'h62;
        endcase
        return u;
    endfunction

    function automatic logic [7:0] control_usage(input logic [2:0] k);
        logic [7:0] u;
        case (k)
            CK_ENTER:     u = 8'h28;
            CK_SPACE:     u = 8'h2c;
            CK_TAB:       u = 8'h2b;
            CK_BACKSPACE: u = 8'h2a;
            CK_ESCAPE:    u = 8'h29;
            default:      u = KEY_NONE;
        endcase
        return u;
    endfunction

    // one shift-add-3 step of binary to bcd conversion
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] b,
                                                 input logic in_bit);
        logic [BCD_W-1:0] c;
        c = b;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (c[4*i +: 4] >= 4'd5) begin
                c[4*i +: 4] = c[4*i +: 4] + 4'd3;
            end
        end
        return {c[BCD_W-2:0], in_bit};
    endfunction

endpackage
`default_nettype wire

### src/achrs_front.sv
`default_nettype none
module achrs_front #(
    parameter int MAX_DIGITS = achrs_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_req_type,
    input  wire logic signed [achrs_pkg::CODE_W-1:0]    s_code_value,
    input  wire logic [2:0]                             s_control_key,
    output logic                                        push,
    input  wire logic                                   full,
    output achrs_pkg::qhead_t                           q_head,
    output logic [$clog2(MAX_DIGITS+1)-1:0]             q_count,
    output logic [4*MAX_DIGITS-1:0]                     q_digits
);
    import achrs_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int LIM    = (MAX_DIGITS < RUN_DIGITS) ? MAX_DIGITS : RUN_DIGITS;
    localparam int STEP_W = $clog2(CONV_STEPS + 1);
    localparam int EXT_D  = (MAX_DIGITS > BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CONV = 3'b010,
        F_EVAL = 3'b100
    } fstate_t;

    fstate_t             state_reg, state_next;
    logic                is_ctl_reg, is_ctl_next;
    logic [2:0]          key_reg, key_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    logic [CODE_W-1:0]   raw;
    logic [CODE_W-1:0]   mag;
    logic [ND_W-1:0]     nd;
    logic                reject;
    logic [4*EXT_D-1:0]  bcd_ext;

    assign raw     = s_code_value;
    assign mag     = raw[CODE_W-1] ? (~raw + CODE_W'(1)) : raw;
    assign bcd_ext = (4*EXT_D)'(bcd_reg);

    // highest nonzero digit sets the count, zero still types one digit
    always_comb begin
        nd = ND_W'(1);
        for (int k = 1; k < BCD_DIGITS; k++) begin
            if (bcd_reg[4*k +: 4] != 4'd0) begin
                nd = ND_W'(k + 1);
            end
        end
    end

    assign reject = (nd > ND_W'(LIM));

    always_comb begin
        state_next  = state_reg;
        is_ctl_next = is_ctl_reg;
        key_next    = key_reg;
        mag_next    = mag_reg;
        bcd_next    = bcd_reg;
        step_next   = step_reg;
        push        = 1'b0;
        case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    is_ctl_next = (s_req_type == REQ_CTL);
                    key_next    = s_control_key;
                    mag_next    = MAG_W'(mag);
                    bcd_next    = '0;
                    step_next   = '0;
                    if (s_req_type == REQ_CTL) begin
                        if (s_control_key inside {[CK_ENTER:CK_ESCAPE]}) begin
                            state_next = F_EVAL;
                        end
                    end else begin
                        state_next = F_CONV;
                    end
                end
            end
            F_CONV: begin
                bcd_next  = dd_step(dd_step(bcd_reg, mag_reg[MAG_W-1]), mag_reg[MAG_W-2]);
                mag_next  = mag_reg << 2;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(CONV_STEPS - 1)) begin
                    state_next = F_EVAL;
                end
            end
            F_EVAL: begin
                if (!is_ctl_reg && reject) begin
                    state_next = F_IDLE;
                end else if (!full) begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign s_ready          = (state_reg == F_IDLE);
    assign q_head.is_ctl    = is_ctl_reg;
    assign q_head.ctl_usage = control_usage(key_reg);
    assign q_count          = CNT_W'(nd);
    assign q_digits         = bcd_ext[4*MAX_DIGITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        is_ctl_reg <= is_ctl_next;
        key_reg    <= key_next;
        mag_reg    <= mag_next;
        bcd_reg    <= bcd_next;
        step_reg   <= step_next;
    end

endmodule
`default_nettype wire

### src/achrs_queue.sv
`default_nettype none
module achrs_queue #(
    parameter int MAX_DIGITS = achrs_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   push,
    output logic                                        full,
    input  wire achrs_pkg::qhead_t                      in_head,
    input  wire logic [$clog2(MAX_DIGITS+1)-1:0]        in_count,
    input  wire logic [4*MAX_DIGITS-1:0]                in_digits,
    input  wire logic                                   pop,
    output logic                                        empty,
    output achrs_pkg::qhead_t                           out_head,
    output logic [$clog2(MAX_DIGITS+1)-1:0]             out_count,
    output logic [4*MAX_DIGITS-1:0]                     out_digits
);
    import achrs_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    qhead_t                  head_mem [QUEUE_DEPTH];
    logic [CNT_W-1:0]        cnt_mem  [QUEUE_DEPTH];
    logic [4*MAX_DIGITS-1:0] dig_mem  [QUEUE_DEPTH];

    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign full    = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    assign out_head   = head_mem[rd_ptr_reg];
    assign out_count  = cnt_mem[rd_ptr_reg];
    assign out_digits = dig_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            head_mem[wr_ptr_reg] <= in_head;
            cnt_mem[wr_ptr_reg]  <= in_count;
            dig_mem[wr_ptr_reg]  <= in_digits;
        end
    end

endmodule
`default_nettype wire

### src/achrs_back.sv
`default_nettype none
module achrs_back #(
    parameter int MAX_DIGITS = achrs_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   empty,
    output logic                                        pop,
    input  wire achrs_pkg::qhead_t                      q_head,
    input  wire logic [$clog2(MAX_DIGITS+1)-1:0]        q_count,
    input  wire logic [4*MAX_DIGITS-1:0]                q_digits,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [7:0]                                  m_modifier,
    output logic [7:0]                                  m_keycode,
    output logic                                        m_last
);
    import achrs_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_OPEN  = 6'b000010,
        B_KEY   = 6'b000100,
        B_GAP   = 6'b001000,
        B_CLOSE = 6'b010000,
        B_CTL   = 6'b100000
    } bstate_t;

    bstate_t                 state_reg, state_next;
    logic [7:0]              usage_reg, usage_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [4*MAX_DIGITS-1:0] dig_reg, dig_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    m_valid_reg, m_valid_next;
    logic [7:0]              mod_reg, mod_next;
    logic [7:0]              key_reg, key_next;
    logic                    last_reg, last_next;

    logic                    advance;
    logic [3:0]              cur_digit;

    assign advance   = !m_valid_reg || m_ready;
    assign cur_digit = dig_reg[4*idx_reg +: 4];

    always_comb begin
        state_next   = state_reg;
        usage_next   = usage_reg;
        cnt_next     = cnt_reg;
        dig_next     = dig_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mod_next     = mod_reg;
        key_next     = key_reg;
        last_next    = last_reg;
        pop          = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (!empty) begin
                    pop        = 1'b1;
                    usage_next = q_head.ctl_usage;
                    cnt_next   = q_count;
                    dig_next   = q_digits;
                    state_next = q_head.is_ctl ? B_CTL : B_OPEN;
                end
            end
            B_OPEN: begin
                if (advance) begin
                    m_valid_next = 1'b1;
                    mod_next     = MOD_ALT;
                    key_next     = KEY_NONE;
                    last_next    = 1'b0;
                    idx_next     = IDX_W'(cnt_reg - CNT_W'(1));
                    state_next   = B_KEY;
                end
            end
            B_KEY: begin
                if (advance) begin
                    m_valid_next = 1'b1;
                    mod_next     = MOD_ALT;
                    key_next     = numpad_usage(cur_digit);
                    last_next    = 1'b0;
                    state_next   = B_GAP;
                end
            end
            B_GAP: begin
                if (advance) begin
                    m_valid_next = 1'b1;
                    mod_next     = MOD_ALT;
                    key_next     = KEY_NONE;
                    last_next    = 1'b0;
                    if (idx_reg == '0) begin
                        state_next = B_CLOSE;
                    end else begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = B_KEY;
                    end
                end
            end
            B_CTL: begin
                if (advance) begin
                    m_valid_next = 1'b1;
                    mod_next     = MOD_NONE;
                    key_next     = usage_reg;
                    last_next    = 1'b0;
                    state_next   = B_CLOSE;
                end
            end
            B_CLOSE: begin
                if (advance) begin
                    m_valid_next = 1'b1;
                    mod_next     = MOD_NONE;
                    key_next     = KEY_NONE;
                    last_next    = 1'b1;
                    state_next   = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign m_modifier = mod_reg;
    assign m_keycode  = key_reg;
    assign m_last     = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        usage_reg <= usage_next;
        cnt_reg   <= cnt_next;
        dig_reg   <= dig_next;
        idx_reg   <= idx_next;
        mod_reg   <= mod_next;
        key_reg   <= key_next;
        last_reg  <= last_next;
    end

endmodule
`default_nettype wire

### src/alt_code_hid_report_sequencer_top.sv
// Alt-code HID report sequencer: one request word in, a run of keyboard
// report words out (modifier byte and first keycode byte, last marks the end).
// Input channel s_*: req_type 0 types the decimal digits of |code_value| as
// numpad keys under held left Alt; req_type 1 presses and releases one
// control key. Codes of more than seven digits and unknown keys give nothing.
// Output channel m_*: one report word per cycle while m_ready is high.
// Front end: an alt-code word is accepted, converted from binary to bcd at
// two bits per cycle, then its digits are counted and it is queued; a control
// word is accepted and then queued. s_ready is high only while the front end is
// free. A two-entry queue separates it from the report sequencer, so the
// next word converts while earlier runs are still being sent.
// Back end: a run of n digits is 2n+2 report words, one per cycle while
// m_ready is high; B_OPEN loads the first word after B_IDLE pops the request.
// A stalled receiver holds the current word in the output register; the
// sequencer waits, the queue fills and then s_ready stays low.
// Reset (aresetn low, synchronous) empties the queue and drops any run.
`default_nettype none
module alt_code_hid_report_sequencer_top #(
    parameter int MAX_DIGITS = achrs_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_req_type,
    input  wire logic signed [achrs_pkg::CODE_W-1:0]    s_code_value,
    input  wire logic [2:0]                             s_control_key,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [7:0]                                  m_modifier,
    output logic [7:0]                                  m_keycode,
    output logic                                        m_last
);
    import achrs_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic                    push, full, pop, empty;
    qhead_t                  f_head, b_head;
    logic [CNT_W-1:0]        f_count, b_count;
    logic [4*MAX_DIGITS-1:0] f_digits, b_digits;

    achrs_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_code_value  (s_code_value),
        .s_control_key (s_control_key),
        .push          (push),
        .full          (full),
        .q_head        (f_head),
        .q_count       (f_count),
        .q_digits      (f_digits)
    );

    achrs_queue #(.MAX_DIGITS(MAX_DIGITS)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .full       (full),
        .in_head    (f_head),
        .in_count   (f_count),
        .in_digits  (f_digits),
        .pop        (pop),
        .empty      (empty),
        .out_head   (b_head),
        .out_count  (b_count),
        .out_digits (b_digits)
    );

    achrs_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .empty      (empty),
        .pop        (pop),
        .q_head     (b_head),
        .q_count    (b_count),
        .q_digits   (b_digits),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_modifier (m_modifier),
        .m_keycode  (m_keycode),
        .m_last     (m_last)
    );

endmodule
`default_nettype wire

### src/achrs_checker.sv
`default_nettype none
module achrs_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_modifier,
    input wire logic [7:0] m_keycode,
    input wire logic       m_last
);
    import achrs_pkg::*;

    // output word held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_modifier)
                                && $stable(m_keycode) && $stable(m_last))
        else $error("report word changed while stalled");

    // run ends with all keys released
    a_last_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_modifier == MOD_NONE && m_keycode == KEY_NONE)
        else $error("final report is not all released");

    // alt-held reports never close a run
    a_alt_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_modifier == MOD_ALT |-> !m_last)
        else $error("run closed with alt held");

    // only left alt or nothing in the modifier byte
    a_mod_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_modifier == MOD_ALT || m_modifier == MOD_NONE)
        else $error("illegal modifier byte");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind alt_code_hid_report_sequencer_top achrs_checker u_achrs_checker (.*);
`default_nettype wire
